/* rtl/core/ilm_pkg.sv */
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared widths, constants and types of the inverse radial lens map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilm_pkg;

  localparam int SRC_W     = 18;
  localparam int OUT_W     = 27;
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int N_W       = 34;
  localparam int D_W       = 27;
  localparam int DMAG_W    = 26;
  localparam int RAD_W     = 17;
  localparam int UQ_W      = 17;
  localparam int U_W       = 18;
  localparam int SQ_W      = 36;
  localparam int RR_W      = 18;
  localparam int TQ_W      = 16;
  localparam int T_W       = 17;
  localparam int TT_W      = 34;
  localparam int PROD_W    = 33;
  localparam int K_W       = 18;
  localparam int KNUM_W    = 37;
  localparam int KQ_W      = 26;
  localparam int RECIP_W   = 32;

  localparam int REFINE_STEPS_DEF = 4;

  localparam logic [REG_W-1:0]   ZOOM_ONE   = 16'd4096;
  localparam logic [RR_W-1:0]    R0_Q16     = 18'd29491;
  localparam logic [TQ_W-1:0]    SPAN_Q16   = 16'd36045;
  // ceil(2^47 / span), product shifted down by 31 gives floor(x * 2^16 / span)
  localparam logic [RECIP_W-1:0] SPAN_RECIP = 32'd3904494059;
  localparam int                 SPAN_SHIFT = 31;
  localparam logic [U_W-1:0]     U_MAX      = 18'd131072;
  localparam logic [T_W-1:0]     T_ONE      = 17'd65536;
  localparam logic [19:0]        K_ONE      = 20'd65536;
  localparam logic [19:0]        K_MIN      = 20'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_X = 2'd0,
    REG_RADIUS_Y = 2'd1,
    REG_ZOOM     = 2'd2,
    REG_WARP     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0]        radius_x;
    logic [REG_W-1:0]        radius_y;
    logic [REG_W-1:0]        zoom;
    logic signed [REG_W-1:0] warp;
  } cfg_t;

  typedef struct packed {
    logic                    mapped;
    logic signed [SRC_W-1:0] px;
    logic signed [SRC_W-1:0] py;
    logic signed [N_W-1:0]   nx;
    logic signed [N_W-1:0]   ny;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
  } item_t;

endpackage

/* rtl/core/ilm_if.sv */
// ----------------------------------------------------------------------------
// ilm_if
// Source point and displayed point channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ilm_src_if import ilm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SRC_W-1:0] src_x;
  logic signed [SRC_W-1:0] src_y;

  modport source (output valid, output src_x, output src_y, input ready);
  modport sink (input valid, input src_x, input src_y, output ready);
endinterface

interface ilm_dst_if import ilm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] disp_x;
  logic signed [OUT_W-1:0] disp_y;
  logic                    was_mapped;

  modport source (output valid, output disp_x, output disp_y, output was_mapped, input ready);
  modport sink (input valid, input disp_x, input disp_y, input was_mapped, output ready);
endinterface

/* rtl/core/ilm_div.sv */
// ----------------------------------------------------------------------------
// ilm_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilm_div #(
  parameter int NumW  = 34,
  parameter int DenW  = 17,
  parameter int QuoW  = 17,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             valid_q [QuoW];
  logic [DenW-1:0]  rem_q   [QuoW];
  logic [DenW-1:0]  den_q   [QuoW];
  logic [QuoW-1:0]  lo_q    [QuoW];
  logic [QuoW-1:0]  quo_q   [QuoW];
  logic [SideW-1:0] side_q  [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    logic             v_in;
    logic [DenW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [QuoW-1:0]  lo_in;
    logic [QuoW-1:0]  quo_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    trial;
    logic [DenW:0]    diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = DenW'(num_i >> QuoW);
      assign den_in  = den_i;
      assign lo_in   = num_i[QuoW-1:0];
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign lo_in   = lo_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = {rem_in, lo_in[QuoW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        den_q[j]  <= den_in;
        lo_q[j]   <= lo_in << 1;
        quo_q[j]  <= {quo_in[QuoW-2:0], ge};
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

/* rtl/core/ilm_sqrt.sv */
// ----------------------------------------------------------------------------
// ilm_sqrt
// Pipelined integer square root, one root bit per stage, side data carried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilm_sqrt #(
  parameter int XW    = 36,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [XW-1:0]    x_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [XW/2-1:0]  root_o,
  output logic [SideW-1:0] side_o
);

  localparam int RW = XW / 2;

  logic             valid_q [RW];
  logic [RW+1:0]    rem_q   [RW];
  logic [RW-1:0]    root_q  [RW];
  logic [XW-1:0]    lo_q    [RW];
  logic [SideW-1:0] side_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic             v_in;
    logic [RW+1:0]    rem_in;
    logic [RW-1:0]    root_in;
    logic [XW-1:0]    lo_in;
    logic [SideW-1:0] side_in;
    logic [RW+3:0]    shifted;
    logic [RW+3:0]    trial;
    logic [RW+3:0]    diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign lo_in   = x_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign lo_in   = lo_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign shifted = {rem_in, lo_in[XW-1:XW-2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign diff    = shifted - trial;
    assign ge      = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
        root_q[j] <= {root_in[RW-2:0], ge};
        lo_q[j]   <= lo_in << 2;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

/* rtl/core/ilm_step.sv */
// ----------------------------------------------------------------------------
// ilm_step
// One refinement step: elliptical radius, warp factor k and d = n / k.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilm_step import ilm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int ItemW = $bits(item_t);

  // radius ratio setup
  logic [DMAG_W-1:0] mag_x, mag_y;
  logic [RAD_W-1:0]  rad_x, rad_y;
  logic              sat_x, sat_y;

  assign mag_x = item_i.dx[D_W-1] ? DMAG_W'(-item_i.dx) : DMAG_W'(item_i.dx);
  assign mag_y = item_i.dy[D_W-1] ? DMAG_W'(-item_i.dy) : DMAG_W'(item_i.dy);
  assign rad_x = {cfg_i.radius_x, 1'b0};
  assign rad_y = {cfg_i.radius_y, 1'b0};
  assign sat_x = mag_x >= DMAG_W'(rad_x);
  assign sat_y = mag_y >= DMAG_W'(rad_y);

  logic                       a_valid_q;
  item_t                      a_item_q;
  logic [U_W+FRAC_W-1:0]      a_num_x_q, a_num_y_q;
  logic                       a_sat_x_q, a_sat_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q  <= item_i;
      a_sat_x_q <= sat_x;
      a_sat_y_q <= sat_y;
      a_num_x_q <= sat_x ? '0 : {mag_x[U_W-1:0], {FRAC_W{1'b0}}};
      a_num_y_q <= sat_y ? '0 : {mag_y[U_W-1:0], {FRAC_W{1'b0}}};
    end
  end

  logic             ux_valid;
  logic [UQ_W-1:0]  ux_quo, uy_quo;
  logic [ItemW:0]   ux_side;
  logic             uy_side;
  item_t            ux_item;

  ilm_div #(.NumW(U_W+FRAC_W), .DenW(RAD_W), .QuoW(UQ_W), .SideW(ItemW+1)) u_div_ux (
    .clk_i, .rst_ni, .en_i,
    .valid_i (a_valid_q),
    .num_i   (a_num_x_q),
    .den_i   (rad_x),
    .side_i  ({a_item_q, a_sat_x_q}),
    .valid_o (ux_valid),
    .quo_o   (ux_quo),
    .side_o  (ux_side)
  );

  ilm_div #(.NumW(U_W+FRAC_W), .DenW(RAD_W), .QuoW(UQ_W), .SideW(1)) u_div_uy (
    .clk_i, .rst_ni, .en_i,
    .valid_i (a_valid_q),
    .num_i   (a_num_y_q),
    .den_i   (rad_y),
    .side_i  (a_sat_y_q),
    .valid_o (),
    .quo_o   (uy_quo),
    .side_o  (uy_side)
  );

  assign ux_item = item_t'(ux_side[ItemW:1]);

  // squares
  logic [U_W-1:0]  ux, uy;
  logic            b_valid_q;
  item_t           b_item_q;
  logic [SQ_W-1:0] b_sq_x_q, b_sq_y_q;

  assign ux = ux_side[0] ? U_MAX : {1'b0, ux_quo};
  assign uy = uy_side ? U_MAX : {1'b0, uy_quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= ux_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_item_q <= ux_item;
      b_sq_x_q <= SQ_W'(ux) * SQ_W'(ux);
      b_sq_y_q <= SQ_W'(uy) * SQ_W'(uy);
    end
  end

  // sum of squares
  logic            c_valid_q;
  item_t           c_item_q;
  logic [SQ_W-1:0] c_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_item_q <= b_item_q;
      c_sum_q  <= b_sq_x_q + b_sq_y_q;
    end
  end

  logic             rr_valid;
  logic [RR_W-1:0]  rr;
  logic [ItemW-1:0] rr_side;

  ilm_sqrt #(.XW(SQ_W), .SideW(ItemW)) u_sqrt (
    .clk_i, .rst_ni, .en_i,
    .valid_i (c_valid_q),
    .x_i     (c_sum_q),
    .side_i  (c_item_q),
    .valid_o (rr_valid),
    .root_o  (rr),
    .side_o  (rr_side)
  );

  // edge ramp t
  logic                   rr_pos, t_sat;
  logic [RR_W-1:0]        rr_diff;
  logic                   d_valid_q;
  item_t                  d_item_q;
  logic                   d_tsat_q;
  logic [TQ_W-1:0]        d_num_q;

  assign rr_pos  = rr > R0_Q16;
  assign rr_diff = rr - R0_Q16;
  assign t_sat   = rr_pos && (rr_diff >= RR_W'(SPAN_Q16));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      d_valid_q <= rr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_item_q <= item_t'(rr_side);
      d_tsat_q <= t_sat;
      d_num_q  <= (rr_pos && !t_sat) ? rr_diff[TQ_W-1:0] : '0;
    end
  end

  // ramp over the span as a reciprocal product
  logic                    tq_valid_q;
  item_t                   tq_item_q;
  logic                    tq_sat_q;
  logic [TQ_W+RECIP_W-1:0] tq_prod_q;
  logic [TQ_W-1:0]         tq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_valid_q <= 1'b0;
    end else if (en_i) begin
      tq_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tq_item_q <= d_item_q;
      tq_sat_q  <= d_tsat_q;
      tq_prod_q <= (TQ_W+RECIP_W)'(d_num_q) * (TQ_W+RECIP_W)'(SPAN_RECIP);
    end
  end

  assign tq = tq_prod_q[SPAN_SHIFT+TQ_W-1:SPAN_SHIFT];

  // t squared
  logic [T_W-1:0]  t_val;
  logic            e_valid_q;
  item_t           e_item_q;
  logic [TT_W-1:0] e_tt_q;

  assign t_val = tq_sat_q ? T_ONE : {1'b0, tq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en_i) begin
      e_valid_q <= tq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_item_q <= tq_item_q;
      e_tt_q   <= TT_W'(t_val) * TT_W'(t_val);
    end
  end

  // w * t2
  logic [TT_W:0]     tt_rnd;
  logic [T_W-1:0]    t2;
  logic [REG_W-1:0]  w_mag;
  logic              f_valid_q;
  item_t             f_item_q;
  logic [PROD_W-1:0] f_prod_q;
  logic              f_wneg_q;

  assign tt_rnd = {1'b0, e_tt_q} + (TT_W+1)'(32768);
  assign t2     = tt_rnd[T_W+FRAC_W-1:FRAC_W];
  assign w_mag  = cfg_i.warp[REG_W-1] ? REG_W'(-cfg_i.warp) : REG_W'(cfg_i.warp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_item_q <= e_item_q;
      f_prod_q <= PROD_W'(w_mag) * PROD_W'(t2);
      f_wneg_q <= cfg_i.warp[REG_W-1];
    end
  end

  // k = max(1 - w*t2, kmin)
  logic [PROD_W:0] prod_rnd;
  logic [K_W-1:0]  q_w;
  logic [19:0]     k_full;
  logic            g_valid_q;
  item_t           g_item_q;
  logic [K_W-1:0]  g_k_q;

  assign prod_rnd = {1'b0, f_prod_q} + (PROD_W+1)'(8192);
  assign q_w      = prod_rnd[K_W+13:14];
  assign k_full   = f_wneg_q ? K_ONE + 20'(q_w) : K_ONE - 20'(q_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (en_i) begin
      g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_item_q <= f_item_q;
      g_k_q    <= ($signed(k_full) < $signed(K_MIN)) ? K_MIN[K_W-1:0] : k_full[K_W-1:0];
    end
  end

  // rounded numerators
  logic [N_W-2:0]    n_mag_x, n_mag_y;
  logic              h_valid_q;
  item_t             h_item_q;
  logic [K_W-1:0]    h_k_q;
  logic [KNUM_W-1:0] h_num_x_q, h_num_y_q;

  assign n_mag_x = g_item_q.nx[N_W-1] ? (N_W-1)'(-g_item_q.nx) : (N_W-1)'(g_item_q.nx);
  assign n_mag_y = g_item_q.ny[N_W-1] ? (N_W-1)'(-g_item_q.ny) : (N_W-1)'(g_item_q.ny);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en_i) begin
      h_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_item_q  <= g_item_q;
      h_k_q     <= g_k_q;
      h_num_x_q <= {n_mag_x, 4'b0000} + KNUM_W'(g_k_q >> 1);
      h_num_y_q <= {n_mag_y, 4'b0000} + KNUM_W'(g_k_q >> 1);
    end
  end

  logic             kx_valid;
  logic [KQ_W-1:0]  kx_quo, ky_quo;
  logic [ItemW-1:0] kx_side;
  logic             ky_neg;

  ilm_div #(.NumW(KNUM_W), .DenW(K_W), .QuoW(KQ_W), .SideW(ItemW)) u_div_dx (
    .clk_i, .rst_ni, .en_i,
    .valid_i (h_valid_q),
    .num_i   (h_num_x_q),
    .den_i   (h_k_q),
    .side_i  (h_item_q),
    .valid_o (kx_valid),
    .quo_o   (kx_quo),
    .side_o  (kx_side)
  );

  ilm_div #(.NumW(KNUM_W), .DenW(K_W), .QuoW(KQ_W), .SideW(1)) u_div_dy (
    .clk_i, .rst_ni, .en_i,
    .valid_i (h_valid_q),
    .num_i   (h_num_y_q),
    .den_i   (h_k_q),
    .side_i  (h_item_q.ny[N_W-1]),
    .valid_o (),
    .quo_o   (ky_quo),
    .side_o  (ky_neg)
  );

  // signed result
  item_t          kx_item, i_next;
  logic [D_W-1:0] qx_ext, qy_ext;
  logic           i_valid_q;
  item_t          i_item_q;

  assign kx_item = item_t'(kx_side);
  assign qx_ext  = {1'b0, kx_quo};
  assign qy_ext  = {1'b0, ky_quo};

  always_comb begin
    i_next    = kx_item;
    i_next.dx = kx_item.nx[N_W-1] ? D_W'(-qx_ext) : qx_ext;
    i_next.dy = ky_neg ? D_W'(-qy_ext) : qy_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_valid_q <= 1'b0;
    end else if (en_i) begin
      i_valid_q <= kx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i_item_q <= i_next;
    end
  end

  assign valid_o = i_valid_q;
  assign item_o  = i_item_q;

endmodule

/* rtl/core/inverse_radial_lens_map.sv */
// ----------------------------------------------------------------------------
// inverse_radial_lens_map
// Registers s0, s1, RefineSteps steps, output register; one word per cycle unless stalled.
// Each step is 71 stages, set by the bit-serial ratio, root and k dividers.
// A stall on the output freezes the whole pipeline; no word is lost or repeated.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_radial_lens_map import ilm_pkg::*; #(
  parameter int RefineSteps = REFINE_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  ilm_src_if.sink              src,
  ilm_dst_if.source            dst
);

  cfg_t cfg_q;
  logic en;
  logic out_valid_q;

  assign en        = !out_valid_q || dst.ready;
  assign src.ready = en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_x <= '0;
      cfg_q.radius_y <= '0;
      cfg_q.zoom     <= ZOOM_ONE;
      cfg_q.warp     <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RADIUS_X: cfg_q.radius_x <= cfg_data_i;
        REG_RADIUS_Y: cfg_q.radius_y <= cfg_data_i;
        REG_ZOOM:     cfg_q.zoom     <= cfg_data_i;
        REG_WARP:     cfg_q.warp     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zoomed point n = p * z
  logic [REG_W-1:0] zoom;
  logic             s0_valid_q;
  item_t            s0_item_q;

  assign zoom = (cfg_q.zoom < ZOOM_ONE) ? ZOOM_ONE : cfg_q.zoom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= src.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q.mapped <= (cfg_q.radius_x != '0) && (cfg_q.radius_y != '0);
      s0_item_q.px     <= src.src_x;
      s0_item_q.py     <= src.src_y;
      s0_item_q.nx     <= N_W'(src.src_x) * N_W'($signed({1'b0, zoom}));
      s0_item_q.ny     <= N_W'(src.src_y) * N_W'($signed({1'b0, zoom}));
      s0_item_q.dx     <= '0;
      s0_item_q.dy     <= '0;
    end
  end

  // starting point d = n / 4096, rounded
  logic [N_W-2:0] n0_mag_x, n0_mag_y;
  logic [N_W-1:0] n0_rnd_x, n0_rnd_y;
  logic [D_W-1:0] d0_x, d0_y;
  logic           s1_valid_q;
  item_t          s1_item_q;
  item_t          s1_item_d;

  assign n0_mag_x = s0_item_q.nx[N_W-1] ? (N_W-1)'(-s0_item_q.nx) : (N_W-1)'(s0_item_q.nx);
  assign n0_mag_y = s0_item_q.ny[N_W-1] ? (N_W-1)'(-s0_item_q.ny) : (N_W-1)'(s0_item_q.ny);
  assign n0_rnd_x = {1'b0, n0_mag_x} + N_W'(2048);
  assign n0_rnd_y = {1'b0, n0_mag_y} + N_W'(2048);
  assign d0_x     = D_W'(n0_rnd_x[N_W-1:12]);
  assign d0_y     = D_W'(n0_rnd_y[N_W-1:12]);

  always_comb begin
    s1_item_d    = s0_item_q;
    s1_item_d.dx = s0_item_q.nx[N_W-1] ? D_W'(-d0_x) : d0_x;
    s1_item_d.dy = s0_item_q.ny[N_W-1] ? D_W'(-d0_y) : d0_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q <= s1_item_d;
    end
  end

  // refinement chain
  logic  chain_valid [RefineSteps+1];
  item_t chain_item  [RefineSteps+1];

  assign chain_valid[0] = s1_valid_q;
  assign chain_item[0]  = s1_item_q;

  for (genvar i = 0; i < RefineSteps; i++) begin : g_step
    ilm_step u_step (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .cfg_i   (cfg_q),
      .valid_i (chain_valid[i]),
      .item_i  (chain_item[i]),
      .valid_o (chain_valid[i+1]),
      .item_o  (chain_item[i+1])
    );
  end

  // output register
  item_t                   last_item;
  logic signed [OUT_W-1:0] out_x_q, out_y_q;
  logic                    out_mapped_q;

  assign last_item = chain_item[RefineSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[RefineSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mapped_q <= last_item.mapped;
      out_x_q      <= last_item.mapped ? OUT_W'(last_item.dx) : OUT_W'(last_item.px);
      out_y_q      <= last_item.mapped ? OUT_W'(last_item.dy) : OUT_W'(last_item.py);
    end
  end

  assign dst.valid      = out_valid_q;
  assign dst.disp_x     = out_x_q;
  assign dst.disp_y     = out_y_q;
  assign dst.was_mapped = out_mapped_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src.valid && src.ready) |=> s0_valid_q)
    else $error("accepted word did not enter the pipeline");

  a_bypass_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_mapped_q) |->
      (out_x_q[OUT_W-1:SRC_W-1] == '0 || out_x_q[OUT_W-1:SRC_W-1] == '1))
    else $error("bypassed word exceeds source range");

  a_zoom_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_ZOOM) |=> (cfg_q.zoom == $past(cfg_data_i)))
    else $error("zoom register write lost");

endmodule
